[rtl/wkh_pkg.sv]
// ----------------------------------------------------------------------------
// wkh_pkg: shared types and constants of the keyword highlighter
// Field widths, register indexes, escape sequences, queue entry and status.
// ----------------------------------------------------------------------------
package wkh_pkg;

  // field widths
  localparam int ByteW    = 8;
  localparam int ColW     = 12;
  localparam int RowW     = 16;
  localparam int PatLenW  = 4;
  localparam int CfgDataW = 64;
  localparam int CfgIdxW  = 3;

  // geometry defaults and caps
  localparam int PatternMaxDef = 8;
  localparam int ColumnCount   = 4096;
  localparam int RowCount      = 65536;
  localparam int ColLastMax    = ColumnCount - 1;
  localparam int RowLastMax    = RowCount - 1;

  // queue between front and back
  localparam int QueueDepth = 4;

  // escape sequences around a match
  localparam int EscLen = 5;
  localparam logic [ByteW-1:0] EscRed [EscLen] = '{8'h1B, 8'h5B, 8'h33, 8'h31, 8'h6D};
  localparam logic [ByteW-1:0] EscRevert [EscLen] = '{8'h1B, 8'h5B, 8'h33, 8'h39, 8'h6D};
  localparam logic [ByteW-1:0] NewlineByte = 8'h0A;
  localparam logic [ByteW-1:0] TermByte    = 8'h00;

  // register reset values
  localparam logic [CfgDataW-1:0] PatternReset = 64'd1684957542;
  localparam logic [PatLenW-1:0]  PatLenReset  = 4'd4;

  // register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_PATTERN_BYTES  = 3'd0,
    CFG_PATTERN_LENGTH = 3'd1,
    CFG_COL_FIRST      = 3'd2,
    CFG_COL_LAST       = 3'd3,
    CFG_ROW_FIRST      = 3'd4,
    CFG_ROW_LAST       = 3'd5
  } cfg_idx_e;

  // operations handed from front to back
  typedef enum logic {
    OP_PUSH  = 1'b0,
    OP_FLUSH = 1'b1
  } op_e;

  // back end sequencer states
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_PRE,
    BK_JUDGE,
    BK_SHIFT,
    BK_HL,
    BK_FLUSH
  } back_state_e;

  typedef struct packed {
    logic [CfgDataW-1:0] pattern_bytes;
    logic [PatLenW-1:0]  pattern_length;
    logic [ColW-1:0]     col_first;
    logic [ColW-1:0]     col_last;
    logic [RowW-1:0]     row_first;
    logic [RowW-1:0]     row_last;
  } cfg_t;

  typedef struct packed {
    op_e              op;
    logic [ByteW-1:0] data;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

[rtl/wkh_if.sv]
// ----------------------------------------------------------------------------
// wkh_if: request and result channels of the keyword highlighter
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface wkh_req_if;
  logic                      valid;
  logic                      ready;
  logic                      req_type;
  logic [wkh_pkg::ByteW-1:0] char_byte;
  logic [wkh_pkg::ColW-1:0]  column;
  logic [wkh_pkg::RowW-1:0]  row;

  modport source (output valid, req_type, char_byte, column, row, input ready);
  modport sink   (input valid, req_type, char_byte, column, row, output ready);
endinterface

interface wkh_res_if;
  logic                      valid;
  logic                      ready;
  logic [wkh_pkg::ByteW-1:0] out_byte;
  logic                      last_out;

  modport source (output valid, out_byte, last_out, input ready);
  modport sink   (input valid, out_byte, last_out, output ready);
endinterface

[rtl/wkh_front.sv]
// ----------------------------------------------------------------------------
// wkh_front: request intake and window classification
// Drops items outside the window, turns row ends into newline or flush ops.
// ----------------------------------------------------------------------------
module wkh_front (
  wkh_req_if.sink             req,
  input  wkh_pkg::cfg_t       cfg_i,
  input  wkh_pkg::q_status_t  q_status_i,
  output logic                push_o,
  output wkh_pkg::q_entry_t   entry_o
);

  logic [wkh_pkg::ColW-1:0] col_last;
  logic [wkh_pkg::RowW-1:0] row_last;
  logic                     row_in;
  logic                     col_in;
  logic                     keep;

  // caps on the last column and row
  assign col_last = (32'(cfg_i.col_last) > wkh_pkg::ColLastMax) ?
                    wkh_pkg::ColW'(wkh_pkg::ColLastMax) : cfg_i.col_last;
  assign row_last = (32'(cfg_i.row_last) > wkh_pkg::RowLastMax) ?
                    wkh_pkg::RowW'(wkh_pkg::RowLastMax) : cfg_i.row_last;

  assign row_in = (req.row >= cfg_i.row_first) && (req.row <= row_last);
  assign col_in = (req.column >= cfg_i.col_first) && (req.column <= col_last);

  // classify the beat
  always_comb begin
    keep          = 1'b0;
    entry_o.op    = wkh_pkg::OP_PUSH;
    entry_o.data  = req.char_byte;
    if (!req.req_type) begin
      keep = row_in && col_in;
    end else if (req.row == row_last) begin
      keep       = 1'b1;
      entry_o.op = wkh_pkg::OP_FLUSH;
    end else begin
      keep         = (req.row >= cfg_i.row_first) && (req.row < row_last);
      entry_o.data = wkh_pkg::NewlineByte;
    end
  end

  assign req.ready = !q_status_i.full;
  assign push_o    = req.valid && req.ready && keep;

endmodule

[rtl/wkh_queue.sv]
// ----------------------------------------------------------------------------
// wkh_queue: small op queue between front and back
// Register-based FIFO that absorbs the output expansion of a match.
// ----------------------------------------------------------------------------
module wkh_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  wkh_pkg::q_entry_t  entry_i,
  input  logic               pop_i,
  output wkh_pkg::q_entry_t  entry_o,
  output wkh_pkg::q_status_t status_o
);

  localparam int PtrW = $clog2(wkh_pkg::QueueDepth);
  localparam int CntW = $clog2(wkh_pkg::QueueDepth + 1);

  wkh_pkg::q_entry_t mem_q [wkh_pkg::QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              do_push;
  logic              do_pop;

  assign status_o.full  = (cnt_q == CntW'(wkh_pkg::QueueDepth));
  assign status_o.empty = (cnt_q == '0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign entry_o = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

[rtl/wkh_back.sv]
// ----------------------------------------------------------------------------
// wkh_back: pending buffer, match sequencer and output register
// Holds bytes that may start a match and emits at most one beat per cycle.
// ----------------------------------------------------------------------------
module wkh_back #(
  parameter int PatternMax = wkh_pkg::PatternMaxDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  wkh_pkg::cfg_t      cfg_i,
  input  logic               q_valid_i,
  input  wkh_pkg::q_entry_t  q_entry_i,
  output logic               q_pop_o,
  wkh_res_if.source          res
);

  localparam int CntW = $clog2(PatternMax + 1);
  localparam int IdxW = $clog2(2 * wkh_pkg::EscLen + PatternMax);

  wkh_pkg::back_state_e     state_q, state_d;
  logic [CntW-1:0]          cnt_q, cnt_d;
  logic [IdxW-1:0]          idx_q, idx_d;
  logic [wkh_pkg::ByteW-1:0] buf_q [PatternMax];
  logic [wkh_pkg::ByteW-1:0] buf_d [PatternMax];
  logic [wkh_pkg::ByteW-1:0] shifted [PatternMax];
  logic [wkh_pkg::ByteW-1:0] byte_q, byte_d;

  logic [CntW-1:0]           len;
  logic [PatternMax:0]       ok;
  logic [IdxW-1:0]           rd_sel;
  logic [wkh_pkg::ByteW-1:0] buf_rd;
  logic [IdxW-1:0]           hl_last;
  logic [IdxW-1:0]           rev_sel;
  logic [wkh_pkg::ByteW-1:0] hl_byte;

  logic                      emit_ok;
  logic                      emit;
  logic [wkh_pkg::ByteW-1:0] emit_byte;
  logic                      emit_last;
  logic                      out_v_q;
  logic [wkh_pkg::ByteW-1:0] out_byte_q;
  logic                      out_last_q;

  // effective pattern length, clamped to 1..PatternMax
  always_comb begin
    if (cfg_i.pattern_length == '0) begin
      len = CntW'(1);
    end else if (32'(cfg_i.pattern_length) > PatternMax) begin
      len = CntW'(PatternMax);
    end else begin
      len = CntW'(cfg_i.pattern_length);
    end
  end

  // prefix flags: ok[n] means the first n held bytes match the pattern
  always_comb begin
    ok[0] = 1'b1;
    for (int i = 0; i < PatternMax; i++) begin
      ok[i+1] = ok[i] && (buf_q[i] == cfg_i.pattern_bytes[8*i +: 8]);
    end
  end

  // buffer shifted down by one
  always_comb begin
    for (int i = 0; i < PatternMax - 1; i++) begin
      shifted[i] = buf_q[i+1];
    end
    shifted[PatternMax-1] = buf_q[PatternMax-1];
  end

  // held byte read for highlight and flush
  assign rd_sel = (state_q == wkh_pkg::BK_HL) ? idx_q - IdxW'(wkh_pkg::EscLen) : idx_q;
  always_comb begin
    buf_rd = buf_q[0];
    for (int i = 0; i < PatternMax; i++) begin
      if (IdxW'(i) == rd_sel) begin
        buf_rd = buf_q[i];
      end
    end
  end

  // byte of a highlighted match
  assign hl_last = IdxW'(len) + IdxW'(2 * wkh_pkg::EscLen - 1);
  assign rev_sel = idx_q - IdxW'(wkh_pkg::EscLen) - IdxW'(len);
  always_comb begin
    if (idx_q < IdxW'(wkh_pkg::EscLen)) begin
      hl_byte = wkh_pkg::EscRed[idx_q[2:0]];
    end else if (idx_q < IdxW'(wkh_pkg::EscLen) + IdxW'(len)) begin
      hl_byte = buf_rd;
    end else begin
      hl_byte = wkh_pkg::EscRevert[rev_sel[2:0]];
    end
  end

  assign emit_ok = !out_v_q || res.ready;

  // sequencer next state
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    buf_d     = buf_q;
    byte_d    = byte_q;
    q_pop_o   = 1'b0;
    emit      = 1'b0;
    emit_byte = buf_q[0];
    emit_last = 1'b0;
    unique case (state_q)
      wkh_pkg::BK_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          if (q_entry_i.op == wkh_pkg::OP_FLUSH) begin
            idx_d   = '0;
            state_d = wkh_pkg::BK_FLUSH;
          end else if (cnt_q == CntW'(PatternMax)) begin
            byte_d  = q_entry_i.data;
            state_d = wkh_pkg::BK_PRE;
          end else begin
            for (int i = 0; i < PatternMax; i++) begin
              if (CntW'(i) == cnt_q) begin
                buf_d[i] = q_entry_i.data;
              end
            end
            cnt_d   = cnt_q + 1'b1;
            state_d = wkh_pkg::BK_JUDGE;
          end
        end
      end
      wkh_pkg::BK_PRE: begin
        // buffer full: shift out the oldest byte, then append
        if (emit_ok) begin
          emit                 = 1'b1;
          emit_byte            = buf_q[0];
          buf_d                = shifted;
          buf_d[PatternMax-1]  = byte_q;
          state_d              = wkh_pkg::BK_JUDGE;
        end
      end
      wkh_pkg::BK_JUDGE: begin
        // match only right after the append, else drain unless a proper prefix
        if (cnt_q == len && ok[len]) begin
          idx_d   = '0;
          state_d = wkh_pkg::BK_HL;
        end else if (cnt_q != '0 && !(cnt_q < len && ok[cnt_q])) begin
          if (emit_ok) begin
            emit      = 1'b1;
            emit_byte = buf_q[0];
            buf_d     = shifted;
            cnt_d     = cnt_q - 1'b1;
            state_d   = wkh_pkg::BK_SHIFT;
          end
        end else begin
          state_d = wkh_pkg::BK_IDLE;
        end
      end
      wkh_pkg::BK_SHIFT: begin
        // drain held bytes until the rest is a proper prefix
        if (cnt_q != '0 && !(cnt_q < len && ok[cnt_q])) begin
          if (emit_ok) begin
            emit      = 1'b1;
            emit_byte = buf_q[0];
            buf_d     = shifted;
            cnt_d     = cnt_q - 1'b1;
          end
        end else begin
          state_d = wkh_pkg::BK_IDLE;
        end
      end
      wkh_pkg::BK_HL: begin
        if (emit_ok) begin
          emit      = 1'b1;
          emit_byte = hl_byte;
          if (idx_q == hl_last) begin
            cnt_d   = '0;
            state_d = wkh_pkg::BK_IDLE;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      wkh_pkg::BK_FLUSH: begin
        if (emit_ok) begin
          emit = 1'b1;
          if (idx_q < IdxW'(cnt_q)) begin
            emit_byte = buf_rd;
            idx_d     = idx_q + 1'b1;
          end else begin
            emit_byte = wkh_pkg::TermByte;
            emit_last = 1'b1;
            cnt_d     = '0;
            state_d   = wkh_pkg::BK_IDLE;
          end
        end
      end
      default: state_d = wkh_pkg::BK_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wkh_pkg::BK_IDLE;
      cnt_q   <= '0;
      idx_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      if (emit) begin
        out_v_q <= 1'b1;
      end else if (res.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // pending bytes and output payload
  always_ff @(posedge clk_i) begin
    buf_q  <= buf_d;
    byte_q <= byte_d;
    if (emit) begin
      out_byte_q <= emit_byte;
      out_last_q <= emit_last;
    end
  end

  assign res.valid    = out_v_q;
  assign res.out_byte = out_byte_q;
  assign res.last_out = out_last_q;

endmodule

[rtl/window_keyword_highlighter_core.sv]
// ----------------------------------------------------------------------------
// window_keyword_highlighter_core: windowed text renderer with highlighting
// Top level: configuration registers, front, op queue and back end.
// ----------------------------------------------------------------------------
// The front takes one request beat per cycle while the four-entry op queue has
// room; characters outside the window and row ends outside the rows are
// dropped there at no cost. The back end handles one queued op at a time and
// sends at most one output beat per cycle through its output register, while
// the receiver is ready: a kept byte is fetched and judged, then each byte it
// shifts out is emitted; a match adds pattern length + 10 beats, and the
// final row end is fetched, then emits each held byte and the terminator.
// The sustained rate is therefore set by the back end sequencer.
module window_keyword_highlighter_core #(
  parameter int PatternMax = wkh_pkg::PatternMaxDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  wkh_req_if.sink                       req,
  wkh_res_if.source                     res,
  input  logic                          cfg_we_i,
  input  logic [wkh_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [wkh_pkg::CfgDataW-1:0]  cfg_wdata_i
);

  wkh_pkg::cfg_t      cfg_q;
  wkh_pkg::q_status_t q_status;
  wkh_pkg::q_entry_t  q_in;
  wkh_pkg::q_entry_t  q_out;
  logic               q_push;
  logic               q_pop;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pattern_bytes  <= wkh_pkg::PatternReset;
      cfg_q.pattern_length <= wkh_pkg::PatLenReset;
      cfg_q.col_first      <= '0;
      cfg_q.col_last       <= wkh_pkg::ColW'(4095);
      cfg_q.row_first      <= '0;
      cfg_q.row_last       <= '0;
    end else if (cfg_we_i) begin
      unique case (wkh_pkg::cfg_idx_e'(cfg_index_i))
        wkh_pkg::CFG_PATTERN_BYTES:  cfg_q.pattern_bytes <= cfg_wdata_i;
        wkh_pkg::CFG_PATTERN_LENGTH: cfg_q.pattern_length <= cfg_wdata_i[wkh_pkg::PatLenW-1:0];
        wkh_pkg::CFG_COL_FIRST:      cfg_q.col_first <= cfg_wdata_i[wkh_pkg::ColW-1:0];
        wkh_pkg::CFG_COL_LAST:       cfg_q.col_last <= cfg_wdata_i[wkh_pkg::ColW-1:0];
        wkh_pkg::CFG_ROW_FIRST:      cfg_q.row_first <= cfg_wdata_i[wkh_pkg::RowW-1:0];
        wkh_pkg::CFG_ROW_LAST:       cfg_q.row_last <= cfg_wdata_i[wkh_pkg::RowW-1:0];
        default: ;
      endcase
    end
  end

  wkh_front u_front (
    .req        (req),
    .cfg_i      (cfg_q),
    .q_status_i (q_status),
    .push_o     (q_push),
    .entry_o    (q_in)
  );

  wkh_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (q_push),
    .entry_i  (q_in),
    .pop_i    (q_pop),
    .entry_o  (q_out),
    .status_o (q_status)
  );

  wkh_back #(
    .PatternMax (PatternMax)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_valid_i (!q_status.empty),
    .q_entry_i (q_out),
    .q_pop_o   (q_pop),
    .res       (res)
  );

  // terminator beat always carries a zero byte
  a_last_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid && res.last_out |-> res.out_byte == wkh_pkg::TermByte)
    else $error("terminator beat with nonzero byte");

  // the front never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_status.full |-> !q_push)
    else $error("op queue overflow");

  // a pushed op is visible to the back end on the next cycle
  a_push_visible: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |=> !q_status.empty)
    else $error("queue empty after push");

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for window_keyword_highlighter_core
// Drives text characters and row ends through the request channel, predicts
// the rendered byte stream (window filter, newlines, highlighted matches and
// terminator) and checks every result beat in order, under varied idling.
// ----------------------------------------------------------------------------
module testbench;

  // request kinds on the input channel
  localparam logic REQ_CHAR    = 1'b0;
  localparam logic REQ_ROW_END = 1'b1;

  // escape sequences, first byte in the top bits
  localparam logic [39:0] RED_SEQ    = 40'h1B5B33316D;
  localparam logic [39:0] REVERT_SEQ = 40'h1B5B33396D;

  localparam int SettleCycles = 100;
  localparam int CycleLimit   = 400000;
  localparam int RandomItems  = 160;

  typedef struct packed {
    logic [wkh_pkg::ByteW-1:0] data;
    logic                      last;
  } text_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                         cfg_we_i;
  logic [wkh_pkg::CfgIdxW-1:0]  cfg_index_i;
  logic [wkh_pkg::CfgDataW-1:0] cfg_wdata_i;

  wkh_req_if req_ch ();
  wkh_res_if res_ch ();

  window_keyword_highlighter_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req         (req_ch),
    .res         (res_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor copy of the registers and the held bytes
  logic [wkh_pkg::CfgDataW-1:0] cfg_pattern;
  logic [wkh_pkg::PatLenW-1:0]  cfg_pat_len;
  logic [wkh_pkg::ColW-1:0]     cfg_col_first;
  logic [wkh_pkg::ColW-1:0]     cfg_col_last;
  logic [wkh_pkg::RowW-1:0]     cfg_row_first;
  logic [wkh_pkg::RowW-1:0]     cfg_row_last;
  logic [wkh_pkg::ByteW-1:0]    held [8];
  int unsigned                  held_count;

  text_beat_t expected_text[$];
  int mismatch_count = 0;
  int cycle_count = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int sent_items = 0;

  // pattern length as the block uses it
  function automatic int unsigned match_length();
    if (cfg_pat_len == 0) return 1;
    if (cfg_pat_len > 8) return 8;
    return cfg_pat_len;
  endfunction

  function automatic bit held_is_prefix(int unsigned n);
    int unsigned i;
    for (i = 0; i < n && i < 8; i++)
      if (held[i] != cfg_pattern[i*8 +: 8]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void note_beat(logic [wkh_pkg::ByteW-1:0] b, logic last);
    text_beat_t beat;
    beat.data = b;
    beat.last = last;
    expected_text.push_back(beat);
  endfunction

  function automatic void shift_held();
    int i;
    note_beat(held[0], 1'b0);
    for (i = 0; i < 7; i++) held[i] = held[i+1];
    held_count--;
  endfunction

  // one kept byte into the match search
  function automatic void push_text(logic [wkh_pkg::ByteW-1:0] b);
    int unsigned n;
    int unsigned i;
    n = match_length();
    while (held_count >= 8) shift_held();
    held[held_count] = b;
    held_count++;
    if (held_count == n && held_is_prefix(n)) begin
      for (i = 0; i < 5; i++) note_beat(RED_SEQ[39-8*i -: 8], 1'b0);
      for (i = 0; i < n; i++) note_beat(held[i], 1'b0);
      for (i = 0; i < 5; i++) note_beat(REVERT_SEQ[39-8*i -: 8], 1'b0);
      held_count = 0;
      return;
    end
    while (held_count > 0 && !(held_count < n && held_is_prefix(held_count)))
      shift_held();
  endfunction

  // expected output of one accepted request; returns 1 if the block acts on it
  function automatic bit render_item(logic kind, logic [wkh_pkg::ByteW-1:0] ch,
                                     logic [wkh_pkg::ColW-1:0] col,
                                     logic [wkh_pkg::RowW-1:0] row);
    int unsigned i;
    if (kind == REQ_CHAR) begin
      if (row >= cfg_row_first && row <= cfg_row_last &&
          col >= cfg_col_first && col <= cfg_col_last) begin
        push_text(ch);
        return 1'b1;
      end
      return 1'b0;
    end
    if (row == cfg_row_last) begin
      for (i = 0; i < held_count; i++) note_beat(held[i], 1'b0);
      held_count = 0;
      note_beat(wkh_pkg::TermByte, 1'b1);
      return 1'b1;
    end
    if (row >= cfg_row_first && row < cfg_row_last) begin
      push_text(wkh_pkg::NewlineByte);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // result checker
  always @(posedge clk_i) begin : check_output
    text_beat_t want;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (expected_text.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected beat: byte %02h last %0b", res_ch.out_byte, res_ch.last_out);
      end else begin
        want = expected_text.pop_front();
        if (res_ch.out_byte !== want.data || res_ch.last_out !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected byte %02h last %0b, got byte %02h last %0b",
                     want.data, want.last, res_ch.out_byte, res_ch.last_out);
        end
      end
    end
  end

  // receiver stalls
  always @(posedge clk_i) begin
    res_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // one request beat, with random idle cycles ahead of it
  task automatic send_item(logic kind, logic [wkh_pkg::ByteW-1:0] ch,
                           logic [wkh_pkg::ColW-1:0] col, logic [wkh_pkg::RowW-1:0] row);
    while ($urandom_range(99) < idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid     <= 1'b1;
    req_ch.req_type  <= kind;
    req_ch.char_byte <= ch;
    req_ch.column    <= col;
    req_ch.row       <= row;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    void'(render_item(kind, ch, col, row));
    sent_items++;
  endtask

  task automatic send_text(string s, int col0, int row);
    int i;
    for (i = 0; i < s.len(); i++)
      send_item(REQ_CHAR, s[i], wkh_pkg::ColW'(col0 + i), wkh_pkg::RowW'(row));
  endtask

  // wait until every expected beat has come and the back end is quiet
  task automatic settle_output();
    req_ch.valid <= 1'b0;
    while (expected_text.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(wkh_pkg::cfg_idx_e idx, logic [wkh_pkg::CfgDataW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      wkh_pkg::CFG_PATTERN_BYTES:  cfg_pattern   = val;
      wkh_pkg::CFG_PATTERN_LENGTH: cfg_pat_len   = val[wkh_pkg::PatLenW-1:0];
      wkh_pkg::CFG_COL_FIRST:      cfg_col_first = val[wkh_pkg::ColW-1:0];
      wkh_pkg::CFG_COL_LAST:       cfg_col_last  = val[wkh_pkg::ColW-1:0];
      wkh_pkg::CFG_ROW_FIRST:      cfg_row_first = val[wkh_pkg::RowW-1:0];
      wkh_pkg::CFG_ROW_LAST:       cfg_row_last  = val[wkh_pkg::RowW-1:0];
      default: ;
    endcase
  endtask

  task automatic load_config(logic [63:0] pat, logic [63:0] plen, logic [63:0] cf,
                             logic [63:0] cl, logic [63:0] rf, logic [63:0] rl);
    write_reg(wkh_pkg::CFG_PATTERN_BYTES, pat);
    write_reg(wkh_pkg::CFG_PATTERN_LENGTH, plen);
    write_reg(wkh_pkg::CFG_COL_FIRST, cf);
    write_reg(wkh_pkg::CFG_COL_LAST, cl);
    write_reg(wkh_pkg::CFG_ROW_FIRST, rf);
    write_reg(wkh_pkg::CFG_ROW_LAST, rl);
    cfg_we_i <= 1'b0;
  endtask

  // reset values: pattern "find", one row
  task automatic test_reset_pattern();
    send_text("find", 0, 0);
    send_item(REQ_ROW_END, 8'hFF, 12'd0, 16'd0);
    settle_output();
  endtask

  // length zero acts as one, length above eight acts as eight
  task automatic test_length_limits();
    load_config(64'hFFFF_FFFF_FFFF_FF00, 64'd0, 64'd0, 64'd4095, 64'd0, 64'd0);
    send_item(REQ_CHAR, 8'hFF, 12'd0, 16'd0);
    send_item(REQ_CHAR, 8'h00, 12'd1, 16'd0);
    send_item(REQ_ROW_END, 8'h00, 12'd0, 16'd0);
    settle_output();
    // eight byte pattern with a newline inside, match spans the row end
    load_config(64'h6766_6564_0A63_6261, 64'd15, 64'd0, 64'd4095, 64'd0, 64'd1);
    send_text("abc", 0, 0);
    send_item(REQ_ROW_END, 8'h00, 12'd0, 16'd0);
    send_text("defg", 0, 1);
    send_item(REQ_ROW_END, 8'h00, 12'd0, 16'd1);
    settle_output();
  endtask

  // window edges, row ends outside the rows, empty window
  task automatic test_window_edges();
    load_config(64'd1684957542, 64'd4, 64'd4094, 64'd4095, 64'd2, 64'd65535);
    send_item(REQ_CHAR, "z", 12'd4095, 16'd2);
    send_item(REQ_CHAR, "q", 12'd4093, 16'd2);
    send_item(REQ_CHAR, "y", 12'd4095, 16'd1);
    send_item(REQ_ROW_END, 8'h00, 12'd0, 16'd1);
    send_item(REQ_ROW_END, 8'h00, 12'd0, 16'd2);
    send_item(REQ_CHAR, "w", 12'd4094, 16'd65535);
    send_item(REQ_ROW_END, 8'h00, 12'd4095, 16'd65535);
    settle_output();
    load_config(64'd1684957542, 64'd4, 64'd9, 64'd8, 64'd4, 64'd3);
    send_item(REQ_CHAR, "k", 12'd8, 16'd3);
    send_item(REQ_ROW_END, 8'h00, 12'd0, 16'd3);
    settle_output();
  endtask

  // pattern rewritten while bytes are held
  task automatic test_pattern_swap();
    load_config(64'h0000_0000_0063_6261, 64'd3, 64'd0, 64'd4095, 64'd0, 64'd0);
    send_text("ab", 0, 0);
    settle_output();
    load_config(64'h0000_0000_0078_6362, 64'd3, 64'd0, 64'd4095, 64'd0, 64'd0);
    send_text("cx", 2, 0);
    send_item(REQ_ROW_END, 8'h00, 12'd0, 16'd0);
    settle_output();
  endtask

  // one random stream: random setup, rows around the window, terminator
  task automatic random_stream();
    logic [63:0] pat;
    logic [63:0] junk;
    int plen, n, cf, cl, rf, rl, r, start, stop, col, cursor, i, chars;
    logic [wkh_pkg::ByteW-1:0] ch;
    for (i = 0; i < 8; i++) begin
      case ($urandom_range(3))
        0: pat[i*8 +: 8] = "a";
        1: pat[i*8 +: 8] = "b";
        2: pat[i*8 +: 8] = wkh_pkg::NewlineByte;
        default: pat[i*8 +: 8] = 8'($urandom_range(255));
      endcase
    end
    plen = ($urandom_range(9) < 7) ? $urandom_range(1, 4) : $urandom_range(15);
    if ($urandom_range(7) == 0) begin
      cf = $urandom_range(4088, 4095);
      cl = 4095;
    end else begin
      cf = $urandom_range(2);
      cl = ($urandom_range(3) == 0) ? 4095 : cf + $urandom_range(4, 12);
    end
    if ($urandom_range(7) == 0) begin
      rf = $urandom_range(65530, 65533);
      rl = rf + $urandom_range(2);
    end else begin
      rf = $urandom_range(3);
      rl = rf + $urandom_range(3);
    end
    if ($urandom_range(11) == 0 && rf > 0) rl = rf - 1;
    junk = {$urandom(), $urandom()};
    if ($urandom_range(1)) junk = '0;
    load_config(pat, {junk[63:4], 4'(plen)}, {junk[63:12], 12'(cf)},
                {junk[63:12], 12'(cl)}, {junk[63:16], 16'(rf)}, {junk[63:16], 16'(rl)});
    n = match_length();
    cursor = 0;
    start = (rf > 0) ? rf - 1 : 0;
    stop = (rl > start) ? rl : start;
    for (r = start; r <= stop; r++) begin
      chars = $urandom_range(8);
      col = (cf > 0) ? cf - 1 : 0;
      for (i = 0; i < chars; i++) begin
        if ($urandom_range(9) == 0) begin
          send_item(REQ_CHAR, 8'($urandom_range(255)), wkh_pkg::ColW'($urandom_range(4095)),
                    wkh_pkg::RowW'($urandom_range(65535)));
        end else begin
          if ($urandom_range(9) < 7) begin
            ch = cfg_pattern[cursor*8 +: 8];
            cursor = (cursor + 1) % n;
          end else begin
            ch = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'("a" + $urandom_range(2));
            cursor = 0;
          end
          send_item(REQ_CHAR, ch, wkh_pkg::ColW'(col), wkh_pkg::RowW'(r));
          col++;
        end
      end
      send_item(REQ_ROW_END, 8'($urandom_range(255)), wkh_pkg::ColW'($urandom_range(4095)),
                wkh_pkg::RowW'(r));
    end
    if (stop != rl)
      send_item(REQ_ROW_END, 8'($urandom_range(255)), wkh_pkg::ColW'($urandom_range(4095)),
                wkh_pkg::RowW'(rl));
    settle_output();
  endtask

  // random streams under each idling mix
  task automatic test_random_streams();
    int phase, goal;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 57; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 57; end
        default: begin idle_pct = 16; stall_pct = 16; end
      endcase
      goal = sent_items + RandomItems / 4;
      while (sent_items < goal) random_stream();
    end
  endtask

  initial begin
    rst_ni           <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_index_i      <= wkh_pkg::CFG_PATTERN_BYTES;
    cfg_wdata_i      <= '0;
    req_ch.valid     <= 1'b0;
    req_ch.req_type  <= REQ_CHAR;
    req_ch.char_byte <= '0;
    req_ch.column    <= '0;
    req_ch.row       <= '0;
    cfg_pattern   = wkh_pkg::PatternReset;
    cfg_pat_len   = wkh_pkg::PatLenReset;
    cfg_col_first = '0;
    cfg_col_last  = wkh_pkg::ColW'(wkh_pkg::ColLastMax);
    cfg_row_first = '0;
    cfg_row_last  = '0;
    held_count    = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_pattern();
    test_length_limits();
    test_window_edges();
    test_pattern_swap();
    test_random_streams();
    settle_output();
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
